// ===== src/bprt_pkg.sv =====
// shared types and constants for the button press repeat tracker
package bprt_pkg;

  localparam int MASK_W  = 9;
  localparam int TIME_W  = 32;
  localparam int MS_W    = 16;
  localparam int SEL_W   = 4;
  localparam int TALLY_W = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [MS_W-1:0] PRESS_MS_RESET        = 16'd50;
  localparam logic [MS_W-1:0] REPEAT_START_MS_RESET = 16'd1000;
  localparam logic [MS_W-1:0] REPEAT_PERIOD_MS_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_MS         = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START_MS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD_MS = 2'd2;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_ACK    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_WAIT_RELEASE = 3'd0,
    PH_WAIT_PRESS   = 3'd1,
    PH_PRESSED      = 3'd2,
    PH_REP_START    = 3'd3,
    PH_REPEATING    = 3'd4
  } phase_t;

  typedef struct packed {
    logic repeated;
    logic clicked;
    logic released;
  } events_t;

  typedef struct packed {
    logic repeating;
    logic let_go;
    logic held;
  } status_t;

  typedef struct packed {
    logic [MS_W-1:0] press_ms;
    logic [MS_W-1:0] repeat_start_ms;
    logic [MS_W-1:0] repeat_period_ms;
  } cfg_t;

  typedef struct packed {
    logic update;
    logic clear;
    logic ack;
    logic down;
    logic hit;
  } lane_ctrl_t;

  typedef struct packed {
    logic               fired;
    events_t            events;
    status_t            status;
    logic [TALLY_W-1:0] tally;
  } lane_view_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [MASK_W-1:0] pressed_mask;
    logic [TIME_W-1:0] now_ms;
    logic [MASK_W-1:0] channel_mask;
    logic [SEL_W-1:0]  count_select;
  } sample_t;

  typedef struct packed {
    logic [MASK_W-1:0]  fired_mask;
    logic [MASK_W-1:0]  clicked_events;
    logic [MASK_W-1:0]  released_events;
    logic [MASK_W-1:0]  repeated_events;
    logic [MASK_W-1:0]  held_flags;
    logic [MASK_W-1:0]  let_go_flags;
    logic [MASK_W-1:0]  repeating_flags;
    logic [TALLY_W-1:0] selected_clicks;
  } result_t;

endpackage

// ===== src/button_press_repeat_tracker_unit.sv =====
// top level of the button press repeat tracker
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------
//  sample   | in        | sample_valid/stall   | sample_t command item
//  result   | out       | result_valid/stall   | result_t flags and count
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one transaction per cycle while sample_stall is low; every channel lane
// steps in the same cycle and the merge stage registers the result for the next cycle
// sample_stall rises only while a result is held and result_stall is high
// synchronous reset puts all lanes in wait for release with cleared flags
// and loads the default hold times; cfg_ready is always high
module button_press_repeat_tracker_unit
  import bprt_pkg::*;
#(
  parameter int CHANNELS = 9
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  sample_t              sample,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data
);

  cfg_t       cfg;
  logic       accept;
  lane_view_t views [CHANNELS];

  assign cfg_ready    = 1'b1;
  assign sample_stall = result_valid && result_stall;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_ms         <= PRESS_MS_RESET;
      cfg.repeat_start_ms  <= REPEAT_START_MS_RESET;
      cfg.repeat_period_ms <= REPEAT_PERIOD_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRESS_MS:         cfg.press_ms         <= cfg_data;
        CFG_REPEAT_START_MS:  cfg.repeat_start_ms  <= cfg_data;
        CFG_REPEAT_PERIOD_MS: cfg.repeat_period_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    lane_ctrl_t ctrl;

    assign ctrl.update = accept && (sample.cmd == CMD_UPDATE);
    assign ctrl.clear  = accept && (sample.cmd == CMD_CLEAR);
    assign ctrl.ack    = accept && (sample.cmd == CMD_ACK);

    if (c < MASK_W) begin : g_wired
      assign ctrl.down = sample.pressed_mask[c];
      assign ctrl.hit  = sample.channel_mask[c];
    end else begin : g_unwired
      assign ctrl.down = 1'b0;
      assign ctrl.hit  = 1'b0;
    end

    bprt_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .cfg    (cfg),
      .ctrl   (ctrl),
      .now_ms (sample.now_ms),
      .view   (views[c])
    );
  end

  bprt_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk          (clk),
    .load         (accept),
    .views        (views),
    .count_select (sample.count_select),
    .result       (result)
  );

endmodule

// ===== src/bprt_lane.sv =====
// per-channel press, click and repeat state machine
module bprt_lane
  import bprt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  lane_ctrl_t        ctrl,
  input  logic [TIME_W-1:0] now_ms,
  output lane_view_t        view
);

  phase_t             phase, phase_next;
  logic [TIME_W-1:0]  mark_time, mark_time_next;
  events_t            events, events_next;
  status_t            status, status_next;
  logic [TALLY_W-1:0] tally, tally_next;
  logic               fired;

  logic [TIME_W-1:0] elapsed;
  logic [MS_W-1:0]   limit;
  logic              press_due;
  logic              repeat_due;

  assign elapsed    = now_ms - mark_time;
  assign limit      = (phase == PH_REP_START) ? cfg.repeat_start_ms : cfg.repeat_period_ms;
  assign press_due  = elapsed >= {{(TIME_W-MS_W){1'b0}}, cfg.press_ms};
  assign repeat_due = elapsed >= {{(TIME_W-MS_W){1'b0}}, limit};

  always_comb begin
    phase_next = phase;
    unique case (phase) inside
      PH_WAIT_PRESS: begin
        if (ctrl.down) phase_next = PH_PRESSED;
      end
      PH_PRESSED: begin
        if (!ctrl.down) phase_next = PH_WAIT_PRESS;
        else if (press_due) phase_next = PH_REP_START;
      end
      PH_REP_START, PH_REPEATING: begin
        if (!ctrl.down) phase_next = PH_PRESSED;
        else if (repeat_due) phase_next = PH_REPEATING;
      end
      default: begin
        phase_next = ctrl.down ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
      end
    endcase
  end

  always_comb begin
    mark_time_next = mark_time;
    events_next    = events;
    status_next    = status;
    tally_next     = tally;
    fired          = 1'b0;
    unique case (phase) inside
      PH_WAIT_PRESS: begin
        if (ctrl.down) begin
          mark_time_next = now_ms;
          tally_next     = '0;
        end
      end
      PH_PRESSED: begin
        if (ctrl.down) begin
          if (press_due) begin
            fired               = 1'b1;
            mark_time_next      = now_ms;
            events_next.clicked = 1'b1;
            status_next.held    = 1'b1;
            tally_next          = tally + 1'b1;
          end
        end else if (status.held) begin
          events_next.released  = 1'b1;
          status_next.let_go    = 1'b1;
          status_next.held      = 1'b0;
          status_next.repeating = 1'b0;
        end
      end
      PH_REP_START, PH_REPEATING: begin
        if (ctrl.down) begin
          if (repeat_due) begin
            fired                 = 1'b1;
            mark_time_next        = now_ms;
            events_next.clicked   = 1'b1;
            events_next.repeated  = 1'b1;
            status_next.repeating = 1'b1;
            tally_next            = tally + 1'b1;
          end
        end else begin
          mark_time_next = now_ms;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_WAIT_RELEASE;
      mark_time <= '0;
      events    <= '0;
      status    <= '0;
      tally     <= '0;
    end else if (ctrl.update) begin
      phase     <= phase_next;
      mark_time <= mark_time_next;
      events    <= events_next;
      status    <= status_next;
      tally     <= tally_next;
    end else if (ctrl.hit && ctrl.clear) begin
      events <= '0;
    end else if (ctrl.hit && ctrl.ack) begin
      events.clicked <= 1'b0;
    end
  end

  // update shows post-step state, other commands show current state
  always_comb begin
    if (ctrl.update) begin
      view.fired  = fired;
      view.events = events_next;
      view.status = status_next;
      view.tally  = tally_next;
    end else begin
      view.fired  = 1'b0;
      view.events = events;
      view.status = status;
      view.tally  = tally;
    end
  end

endmodule

// ===== src/bprt_merge.sv =====
// gathers lane views into the registered result
module bprt_merge
  import bprt_pkg::*;
#(
  parameter int CHANNELS = 9
) (
  input  logic             clk,
  input  logic             load,
  input  lane_view_t       views [CHANNELS],
  input  logic [SEL_W-1:0] count_select,
  output result_t          result
);

  result_t merged;

  always_comb begin
    merged = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < MASK_W) begin
        merged.fired_mask[c]      = views[c].fired;
        merged.clicked_events[c]  = views[c].events.clicked;
        merged.released_events[c] = views[c].events.released;
        merged.repeated_events[c] = views[c].events.repeated;
        merged.held_flags[c]      = views[c].status.held;
        merged.let_go_flags[c]    = views[c].status.let_go;
        merged.repeating_flags[c] = views[c].status.repeating;
      end
      if (int'(count_select) == c) merged.selected_clicks = views[c].tally;
    end
  end

  always_ff @(posedge clk) begin
    if (load) result <= merged;
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench for the button press repeat tracker: lane prediction, directed and random samples
module tb_top;
  import bprt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = 9;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]      cfg_data = '0;

  button_press_repeat_tracker_unit #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // lane state mirror
  phase_t             lane_phase  [CHANNELS];
  logic [TIME_W-1:0]  lane_mark   [CHANNELS];
  events_t            lane_events [CHANNELS];
  status_t            lane_status [CHANNELS];
  logic [TALLY_W-1:0] lane_clicks [CHANNELS];
  cfg_t               timing;

  result_t            button_reports [$];
  result_t            oldest_report;
  int                 mismatch_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  logic [TIME_W-1:0]  clock_ms = '0;
  logic [MASK_W-1:0]  keys_down = '0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[button_press_repeat_tracker_unit] ERROR");
    $finish;
  end

  function automatic result_t step_buttons(input sample_t s);
    result_t           r;
    logic [TIME_W-1:0] elapsed;
    logic [MS_W-1:0]   limit;
    logic              down;
    int                c;
    r = '0;
    if (s.cmd == CMD_UPDATE) begin
      for (c = 0; c < CHANNELS; c++) begin
        down = s.pressed_mask[c];
        elapsed = s.now_ms - lane_mark[c];
        case (lane_phase[c])
          PH_WAIT_PRESS: begin
            if (down) begin
              lane_phase[c] = PH_PRESSED;
              lane_mark[c] = s.now_ms;
              lane_clicks[c] = '0;
            end
          end
          PH_PRESSED: begin
            if (down) begin
              if (elapsed >= timing.press_ms) begin
                r.fired_mask[c] = 1'b1;
                lane_phase[c] = PH_REP_START;
                lane_mark[c] = s.now_ms;
                lane_events[c].clicked = 1'b1;
                lane_status[c].held = 1'b1;
                lane_clicks[c] = lane_clicks[c] + 1'b1;
              end
            end else begin
              lane_phase[c] = PH_WAIT_PRESS;
              if (lane_status[c].held) begin
                lane_events[c].released = 1'b1;
                lane_status[c].let_go = 1'b1;
                lane_status[c].held = 1'b0;
                lane_status[c].repeating = 1'b0;
              end
            end
          end
          PH_REP_START, PH_REPEATING: begin
            if (down) begin
              limit = (lane_phase[c] == PH_REP_START) ? timing.repeat_start_ms
                                                      : timing.repeat_period_ms;
              if (elapsed >= limit) begin
                r.fired_mask[c] = 1'b1;
                lane_phase[c] = PH_REPEATING;
                lane_mark[c] = s.now_ms;
                lane_events[c].clicked = 1'b1;
                lane_events[c].repeated = 1'b1;
                lane_status[c].repeating = 1'b1;
                lane_clicks[c] = lane_clicks[c] + 1'b1;
              end
            end else begin
              lane_phase[c] = PH_PRESSED;
              lane_mark[c] = s.now_ms;
            end
          end
          default: begin
            lane_phase[c] = down ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
          end
        endcase
      end
    end
    for (c = 0; c < CHANNELS; c++) begin
      r.clicked_events[c]  = lane_events[c].clicked;
      r.released_events[c] = lane_events[c].released;
      r.repeated_events[c] = lane_events[c].repeated;
      r.held_flags[c]      = lane_status[c].held;
      r.let_go_flags[c]    = lane_status[c].let_go;
      r.repeating_flags[c] = lane_status[c].repeating;
    end
    if (s.cmd == CMD_CLEAR || s.cmd == CMD_ACK) begin
      for (c = 0; c < CHANNELS; c++) begin
        if (s.channel_mask[c]) begin
          if (s.cmd == CMD_CLEAR) lane_events[c] = '0;
          else lane_events[c].clicked = 1'b0;
        end
      end
    end
    r.selected_clicks = (s.count_select < CHANNELS) ? lane_clicks[s.count_select] : '0;
    return r;
  endfunction

  function automatic sample_t make_sample(input cmd_t cmd, input logic [MASK_W-1:0] keys,
                                          input logic [TIME_W-1:0] at_ms,
                                          input logic [MASK_W-1:0] lanes,
                                          input logic [SEL_W-1:0] sel);
    sample_t s;
    s.cmd = cmd;
    s.pressed_mask = keys;
    s.now_ms = at_ms;
    s.channel_mask = lanes;
    s.count_select = sel;
    return s;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 50)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // receiver stall pattern
  initial begin
    forever begin
      @(negedge clk);
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (button_reports.size() == 0) begin
        report_mismatch("result with nothing pending", result.fired_mask, '0);
      end else begin
        oldest_report = button_reports.pop_front();
        if (result.fired_mask !== oldest_report.fired_mask)
          report_mismatch("fired_mask", result.fired_mask, oldest_report.fired_mask);
        if (result.clicked_events !== oldest_report.clicked_events)
          report_mismatch("clicked_events", result.clicked_events,
                          oldest_report.clicked_events);
        if (result.released_events !== oldest_report.released_events)
          report_mismatch("released_events", result.released_events,
                          oldest_report.released_events);
        if (result.repeated_events !== oldest_report.repeated_events)
          report_mismatch("repeated_events", result.repeated_events,
                          oldest_report.repeated_events);
        if (result.held_flags !== oldest_report.held_flags)
          report_mismatch("held_flags", result.held_flags, oldest_report.held_flags);
        if (result.let_go_flags !== oldest_report.let_go_flags)
          report_mismatch("let_go_flags", result.let_go_flags, oldest_report.let_go_flags);
        if (result.repeating_flags !== oldest_report.repeating_flags)
          report_mismatch("repeating_flags", result.repeating_flags,
                          oldest_report.repeating_flags);
        if (result.selected_clicks !== oldest_report.selected_clicks)
          report_mismatch("selected_clicks", result.selected_clicks,
                          oldest_report.selected_clicks);
      end
    end
  end

  // valid stays high after acceptance until the next call or a drain
  task automatic send_sample(input sample_t s);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    button_reports.push_back(step_buttons(s));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (button_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [MS_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PRESS_MS:         timing.press_ms = val;
      CFG_REPEAT_START_MS:  timing.repeat_start_ms = val;
      CFG_REPEAT_PERIOD_MS: timing.repeat_period_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timing(input logic [MS_W-1:0] press, input logic [MS_W-1:0] start,
                            input logic [MS_W-1:0] period);
    wait_drained();
    write_register(CFG_PRESS_MS, press);
    write_register(CFG_REPEAT_START_MS, start);
    write_register(CFG_REPEAT_PERIOD_MS, period);
  endtask

  // mostly continuous time with slowly changing keys, plus some noise
  task automatic run_random(input int count, input int max_step, input int toggle_pct);
    sample_t s;
    int      pick;
    int      i;
    int      c;
    for (i = 0; i < count; i++) begin
      clock_ms = clock_ms + $urandom_range(max_step);
      if ($urandom_range(99) < 2) clock_ms = $urandom();
      for (c = 0; c < CHANNELS; c++)
        if ($urandom_range(99) < toggle_pct) keys_down[c] = ~keys_down[c];
      if ($urandom_range(99) < 3) keys_down = MASK_W'($urandom());
      pick = $urandom_range(99);
      s.now_ms = clock_ms;
      s.pressed_mask = keys_down;
      s.channel_mask = MASK_W'($urandom());
      s.count_select = SEL_W'($urandom_range(15));
      if (pick < 80) begin
        s.cmd = CMD_UPDATE;
      end else begin
        s.pressed_mask = MASK_W'($urandom());
        s.now_ms = $urandom();
        if (pick < 88) s.cmd = CMD_CLEAR;
        else if (pick < 96) s.cmd = CMD_ACK;
        else s.cmd = CMD_NOP;
      end
      send_sample(s);
    end
  endtask

  task automatic test_directed();
    send_sample(make_sample(CMD_NOP, 9'h1FF, 32'hFFFF_FFFF, 9'h1FF, 4'd15));
    send_sample(make_sample(CMD_UPDATE, 9'h000, 32'd0, 9'h000, 4'd9));
    send_sample(make_sample(CMD_UPDATE, 9'h1FF, 32'd10, 9'h000, 4'd0));
    send_sample(make_sample(CMD_UPDATE, 9'h1FF, 32'd59, 9'h000, 4'd0));
    send_sample(make_sample(CMD_UPDATE, 9'h1FF, 32'd60, 9'h000, 4'd0));
    send_sample(make_sample(CMD_UPDATE, 9'h0FF, 32'd100, 9'h000, 4'd8));
    send_sample(make_sample(CMD_UPDATE, 9'h0FF, 32'd1059, 9'h000, 4'd1));
    send_sample(make_sample(CMD_UPDATE, 9'h0FF, 32'd1060, 9'h000, 4'd3));
    send_sample(make_sample(CMD_UPDATE, 9'h0FF, 32'd1160, 9'h000, 4'd7));
    send_sample(make_sample(CMD_UPDATE, 9'h0F0, 32'd1170, 9'h000, 4'd4));
    send_sample(make_sample(CMD_UPDATE, 9'h000, 32'd1180, 9'h000, 4'd2));
    send_sample(make_sample(CMD_ACK, 9'h1FF, 32'd0, 9'h0AA, 4'd8));
    send_sample(make_sample(CMD_CLEAR, 9'h000, 32'd0, 9'h155, 4'd9));
    send_sample(make_sample(CMD_UPDATE, 9'h000, 32'd1190, 9'h000, 4'd5));
    // press just before the timestamp wraps
    send_sample(make_sample(CMD_UPDATE, 9'h001, 32'hFFFF_FFF0, 9'h000, 4'd0));
    send_sample(make_sample(CMD_UPDATE, 9'h001, 32'h0000_0021, 9'h000, 4'd0));
    send_sample(make_sample(CMD_UPDATE, 9'h001, 32'h0000_0022, 9'h000, 4'd0));
    send_sample(make_sample(CMD_UPDATE, 9'h002, 32'h0000_0030, 9'h000, 4'd1));
    send_sample(make_sample(CMD_UPDATE, 9'h000, 32'h0000_0040, 9'h000, 4'd1));
    send_sample(make_sample(CMD_ACK, 9'h000, 32'h0, 9'h1FF, 4'd6));
    send_sample(make_sample(CMD_CLEAR, 9'h1FF, 32'hFFFF_FFFF, 9'h1FF, 4'd4));
    send_sample(make_sample(CMD_NOP, 9'h000, 32'h0, 9'h000, 4'd0));
    clock_ms = 32'h0000_0040;
  endtask

  task automatic test_zero_timing();
    set_timing('0, '0, '0);
    run_random(150, 3, 10);
  endtask

  task automatic test_fast_repeat();
    set_timing(16'd4, 16'd20, 16'd6);
    run_random(250, 5, 6);
  endtask

  task automatic test_max_timing();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(100, 40000, 8);
  endtask

  task automatic test_mixed_timing();
    int round;
    for (round = 0; round < 2; round++) begin
      set_timing(MS_W'($urandom_range(20)), MS_W'($urandom_range(60)),
                 MS_W'($urandom_range(15)));
      run_random(125, 10, 6);
    end
  endtask

  task automatic test_default_timing();
    set_timing(PRESS_MS_RESET, REPEAT_START_MS_RESET, REPEAT_PERIOD_MS_RESET);
    run_random(250, 120, 5);
  endtask

  initial begin
    timing.press_ms = PRESS_MS_RESET;
    timing.repeat_start_ms = REPEAT_START_MS_RESET;
    timing.repeat_period_ms = REPEAT_PERIOD_MS_RESET;
    for (int c = 0; c < CHANNELS; c++) begin
      lane_phase[c] = PH_WAIT_RELEASE;
      lane_mark[c] = '0;
      lane_events[c] = '0;
      lane_status[c] = '0;
      lane_clicks[c] = '0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 63;
    test_directed();
    test_zero_timing();
    test_fast_repeat();

    send_idle_pct = 63;
    recv_idle_pct = 30;
    test_max_timing();
    test_mixed_timing();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_default_timing();

    wait_drained();
    if (mismatch_count == 0) begin
      $display("[button_press_repeat_tracker_unit] OK");
    end else begin
      $display("[button_press_repeat_tracker_unit] ERROR");
    end
    $finish;
  end

endmodule
